// ===== sv/urupf_pkg.sv =====
// ----------------------------------------------------------------------------
// urupf_pkg
// Shared types, codes and header layout constants of the UDP rule update
// packet filter.
// ----------------------------------------------------------------------------
package urupf_pkg;

  localparam int HDR_LEN = 46;
  localparam int IDX_W = 6;
  localparam int HDR_AW = IDX_W + 1;

  localparam logic [IDX_W-1:0] HDR_LAST = 6'd45;
  localparam logic [IDX_W-1:0] HDR_FULL = 6'd46;

  localparam logic [IDX_W-1:0] POS_ETYPE_HI = 6'd12;
  localparam logic [IDX_W-1:0] POS_ETYPE_LO = 6'd13;
  localparam logic [IDX_W-1:0] POS_PROTO = 6'd23;
  localparam logic [IDX_W-1:0] POS_DPORT_HI = 6'd36;
  localparam logic [IDX_W-1:0] POS_DPORT_LO = 6'd37;
  localparam logic [IDX_W-1:0] POS_RESP = 6'd42;
  localparam logic [IDX_W-1:0] POS_CMD = 6'd43;
  localparam logic [IDX_W-1:0] POS_KEY_HI = 6'd44;
  localparam logic [IDX_W-1:0] POS_KEY_LO = 6'd45;

  localparam logic [IDX_W-1:0] LEN_ETH = 6'd14;
  localparam logic [IDX_W-1:0] LEN_IP = 6'd34;
  localparam logic [IDX_W-1:0] LEN_UDP = 6'd42;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] CMD_MAX = 8'd1;
  localparam logic [7:0] RESP_CODE = 8'd1;
  localparam logic [15:0] CONTROL_PORT_RESET = 16'd4242;

  localparam logic [1:0] VERDICT_PASS = 2'd0;
  localparam logic [1:0] VERDICT_TX = 2'd1;
  localparam logic [1:0] VERDICT_ABORT = 2'd2;

  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0] verdict;
    logic [15:0] key;
    logic cmd_bit;
  } judge_t;

  // Source position of each output header byte: MACs, IPs and ports swapped.
  function automatic logic [IDX_W-1:0] hdr_src(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] src;
    src = idx;
    if (idx < 6'd6) begin
      src = idx + 6'd6;
    end else if (idx < 6'd12) begin
      src = idx - 6'd6;
    end else if (idx >= 6'd26 && idx < 6'd30) begin
      src = idx + 6'd4;
    end else if (idx >= 6'd30 && idx < 6'd34) begin
      src = idx - 6'd4;
    end else if (idx == 6'd34 || idx == 6'd35) begin
      src = idx + 6'd2;
    end else if (idx == 6'd36 || idx == 6'd37) begin
      src = idx - 6'd2;
    end
    return src;
  endfunction

endpackage

// ===== sv/urupf_hdr_mem.sv =====
// ----------------------------------------------------------------------------
// urupf_hdr_mem
// Two banks of header bytes: one written by the incoming packet while the
// other is read out for the reply.
// ----------------------------------------------------------------------------
module urupf_hdr_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [urupf_pkg::HDR_AW-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic                       re,
  input  logic [urupf_pkg::HDR_AW-1:0] raddr,
  output logic [7:0]                 rdata
);

  logic [7:0] mem [0:(1 << urupf_pkg::HDR_AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/urupf_rule_mem.sv =====
// ----------------------------------------------------------------------------
// urupf_rule_mem
// Rule bit table with a clearing pass after reset, one entry per cycle.
// ----------------------------------------------------------------------------
module urupf_rule_mem #(
  parameter int ENTRIES = 65536,
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          rst,
  output logic          busy,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [0:ENTRIES-1];
  logic [AW-1:0] clr_addr;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(ENTRIES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign mem_we = busy || we;
  assign mem_waddr = busy ? clr_addr : waddr;
  assign mem_wdata = busy ? 1'b0 : wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/urupf_parser.sv =====
// ----------------------------------------------------------------------------
// urupf_parser
// Counts packet bytes, picks out the header fields on the fly and judges
// the packet on its last byte.
// ----------------------------------------------------------------------------
module urupf_parser #(
  parameter int RULE_ENTRIES = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [15:0]                 control_port,
  input  logic                        byte_valid,
  input  logic [7:0]                  data_byte,
  input  logic                        last,
  output logic                        wr_en,
  output logic [urupf_pkg::IDX_W-1:0] wr_idx,
  output urupf_pkg::judge_t           judge
);

  logic [urupf_pkg::IDX_W-1:0] byte_count;
  logic [urupf_pkg::IDX_W-1:0] byte_count_next;
  logic [urupf_pkg::IDX_W-1:0] n_after;
  logic stored;
  logic [7:0] etype_hi, etype_lo, proto, dport_hi, dport_lo, cmd, key_hi, key_lo;
  logic [7:0] etype_hi_e, etype_lo_e, proto_e, dport_hi_e, dport_lo_e;
  logic [7:0] cmd_e, key_hi_e, key_lo_e;
  logic [15:0] key;
  logic is_update;

  assign stored = byte_count < urupf_pkg::HDR_FULL;
  assign wr_en = byte_valid && stored;
  assign wr_idx = byte_count;
  assign n_after = stored ? byte_count + 6'd1 : byte_count;

  always_comb begin
    byte_count_next = byte_count;
    if (byte_valid) begin
      byte_count_next = last ? '0 : n_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (byte_count)
        urupf_pkg::POS_ETYPE_HI: etype_hi <= data_byte;
        urupf_pkg::POS_ETYPE_LO: etype_lo <= data_byte;
        urupf_pkg::POS_PROTO: proto <= data_byte;
        urupf_pkg::POS_DPORT_HI: dport_hi <= data_byte;
        urupf_pkg::POS_DPORT_LO: dport_lo <= data_byte;
        urupf_pkg::POS_CMD: cmd <= data_byte;
        urupf_pkg::POS_KEY_HI: key_hi <= data_byte;
        urupf_pkg::POS_KEY_LO: key_lo <= data_byte;
        default: ;
      endcase
    end
  end

  // The byte in flight counts as already stored.
  assign etype_hi_e = (stored && byte_count == urupf_pkg::POS_ETYPE_HI) ? data_byte : etype_hi;
  assign etype_lo_e = (stored && byte_count == urupf_pkg::POS_ETYPE_LO) ? data_byte : etype_lo;
  assign proto_e = (stored && byte_count == urupf_pkg::POS_PROTO) ? data_byte : proto;
  assign dport_hi_e = (stored && byte_count == urupf_pkg::POS_DPORT_HI) ? data_byte : dport_hi;
  assign dport_lo_e = (stored && byte_count == urupf_pkg::POS_DPORT_LO) ? data_byte : dport_lo;
  assign cmd_e = (stored && byte_count == urupf_pkg::POS_CMD) ? data_byte : cmd;
  assign key_hi_e = (stored && byte_count == urupf_pkg::POS_KEY_HI) ? data_byte : key_hi;
  assign key_lo_e = (stored && byte_count == urupf_pkg::POS_KEY_LO) ? data_byte : key_lo;

  assign key = {key_hi_e, key_lo_e};

  assign is_update = n_after >= urupf_pkg::LEN_ETH
      && {etype_hi_e, etype_lo_e} == urupf_pkg::ETYPE_IPV4
      && n_after >= urupf_pkg::LEN_IP && proto_e == urupf_pkg::PROTO_UDP
      && n_after >= urupf_pkg::LEN_UDP && {dport_hi_e, dport_lo_e} == control_port
      && n_after == urupf_pkg::HDR_FULL && cmd_e <= urupf_pkg::CMD_MAX;

  always_comb begin
    judge.key = key;
    judge.cmd_bit = cmd_e[0];
    if (!is_update) begin
      judge.verdict = urupf_pkg::VERDICT_PASS;
    end else if ({1'b0, key} >= 17'(RULE_ENTRIES)) begin
      judge.verdict = urupf_pkg::VERDICT_ABORT;
    end else begin
      judge.verdict = urupf_pkg::VERDICT_TX;
    end
  end

endmodule

// ===== sv/udp_rule_update_packet_filter.sv =====
// ----------------------------------------------------------------------------
// udp_rule_update_packet_filter
// Rule update packet filter with reply header generation and rule queries.
// ----------------------------------------------------------------------------
// The slave channel carries packet bytes (tuser 0, tlast on the final byte)
// and rule queries (tuser 1). The master channel returns one word per query,
// one verdict word per packet, and for an accepted rule update the verdict
// followed by the 46 rewritten header bytes, tlast on the last word of each.
// Packet bytes that are not last are taken every cycle once the rule table
// is cleared and only fill the header buffer. A query answers in the cycle
// after it is taken, a verdict in the cycle after the last byte; the reply
// header then streams one byte a cycle while the receiver is ready, read
// from one bank of a two-bank header memory while the next packet fills
// the other bank. A query or a last byte waits while a reply header is
// still streaming. When the receiver stalls, the output word and the memory
// read registers hold and the block takes no word that produces a result.
// After reset the rule table is cleared to block, one entry a cycle, with
// tready low; control_port returns to 4242 and can be written through
// cfg_wen and cfg_wdata at any time while idle.
// ----------------------------------------------------------------------------
module udp_rule_update_packet_filter #(
  parameter int RULE_ENTRIES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // data_byte[7:0], rule_port[23:8]
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // verdict[1:0], header_byte[9:2],
                                      // rule_allowed[10], zero[15:11]
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser    // out_kind[1:0]
);

  localparam int AW = $clog2(RULE_ENTRIES);

  logic [15:0] control_port;
  logic clr_busy;
  logic adv;
  logic in_acc, q_acc, b_acc, last_acc;
  logic [15:0] rule_port;
  logic q_oob;

  logic p1_valid;
  logic [1:0] p1_kind;
  logic [1:0] p1_verdict;
  logic p1_last;
  logic p1_force_one;
  logic p1_oob;

  logic emitting;
  logic [urupf_pkg::IDX_W-1:0] emit_cnt;
  logic emit_bank;
  logic wr_bank;

  logic hdr_wr_en;
  logic [urupf_pkg::IDX_W-1:0] hdr_wr_idx;
  urupf_pkg::judge_t judge;
  logic [7:0] hdr_rdata;
  logic rule_rdata;
  logic rule_we;

  logic [1:0] out_verdict;
  logic [7:0] out_byte;
  logic out_allowed;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_port <= urupf_pkg::CONTROL_PORT_RESET;
    end else if (cfg_wen) begin
      control_port <= cfg_wdata;
    end
  end

  assign adv = !p1_valid || m_axis_tready;
  assign s_axis_tready = !clr_busy
      && ((!s_axis_tuser && !s_axis_tlast) || (adv && !emitting));
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign q_acc = in_acc && s_axis_tuser;
  assign b_acc = in_acc && !s_axis_tuser;
  assign last_acc = b_acc && s_axis_tlast;
  assign rule_port = s_axis_tdata[23:8];
  assign q_oob = {1'b0, rule_port} >= 17'(RULE_ENTRIES);
  assign rule_we = last_acc && judge.verdict == urupf_pkg::VERDICT_TX;

  urupf_parser #(
    .RULE_ENTRIES(RULE_ENTRIES)
  ) u_parser (
    .clk(clk),
    .rst(rst),
    .control_port(control_port),
    .byte_valid(b_acc),
    .data_byte(s_axis_tdata[7:0]),
    .last(s_axis_tlast),
    .wr_en(hdr_wr_en),
    .wr_idx(hdr_wr_idx),
    .judge(judge)
  );

  urupf_hdr_mem u_hdr_mem (
    .clk(clk),
    .we(hdr_wr_en),
    .waddr({wr_bank, hdr_wr_idx}),
    .wdata(s_axis_tdata[7:0]),
    .re(adv),
    .raddr({emit_bank, urupf_pkg::hdr_src(emit_cnt)}),
    .rdata(hdr_rdata)
  );

  urupf_rule_mem #(
    .ENTRIES(RULE_ENTRIES),
    .AW(AW)
  ) u_rule_mem (
    .clk(clk),
    .rst(rst),
    .busy(clr_busy),
    .we(rule_we),
    .waddr(judge.key[AW-1:0]),
    .wdata(judge.cmd_bit),
    .re(adv),
    .raddr(rule_port[AW-1:0]),
    .rdata(rule_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      emitting <= 1'b0;
      emit_cnt <= '0;
      emit_bank <= 1'b0;
      wr_bank <= 1'b0;
    end else if (adv) begin
      if (emitting) begin
        p1_valid <= 1'b1;
        emit_cnt <= emit_cnt + 6'd1;
        if (emit_cnt == urupf_pkg::HDR_LAST) begin
          emitting <= 1'b0;
        end
      end else if (q_acc || last_acc) begin
        p1_valid <= 1'b1;
        if (rule_we) begin
          emitting <= 1'b1;
          emit_cnt <= '0;
          emit_bank <= wr_bank;
          wr_bank <= !wr_bank;
        end
      end else begin
        p1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_force_one <= 1'b0;
      p1_oob <= q_oob;
      p1_verdict <= urupf_pkg::VERDICT_PASS;
      if (emitting) begin
        p1_kind <= urupf_pkg::KIND_HEADER;
        p1_last <= emit_cnt == urupf_pkg::HDR_LAST;
        p1_force_one <= emit_cnt == urupf_pkg::POS_RESP;
      end else if (q_acc) begin
        p1_kind <= urupf_pkg::KIND_QUERY;
        p1_last <= 1'b1;
      end else begin
        p1_kind <= urupf_pkg::KIND_VERDICT;
        p1_verdict <= judge.verdict;
        p1_last <= judge.verdict != urupf_pkg::VERDICT_TX;
      end
    end
  end

  always_comb begin
    out_verdict = 2'd0;
    out_byte = 8'd0;
    out_allowed = 1'b0;
    case (p1_kind)
      urupf_pkg::KIND_VERDICT: out_verdict = p1_verdict;
      urupf_pkg::KIND_HEADER: out_byte = p1_force_one ? urupf_pkg::RESP_CODE : hdr_rdata;
      urupf_pkg::KIND_QUERY: out_allowed = rule_rdata && !p1_oob;
      default: ;
    endcase
  end

  assign m_axis_tvalid = p1_valid;
  assign m_axis_tdata = {5'd0, out_allowed, out_byte, out_verdict};
  assign m_axis_tlast = p1_last;
  assign m_axis_tuser = p1_kind;

endmodule

// ===== test/urupf_reply_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urupf_reply_check
// Watches both stream channels and the control port register of the rule
// update packet filter. It keeps its own header buffer, rule table and
// control port, works out the result words of every accepted input word and
// compares each accepted result word with the oldest one still owed.
// ----------------------------------------------------------------------------
module urupf_reply_check #(
  parameter int RULE_ENTRIES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic [1:0]  m_axis_tuser,
  output int          outstanding,
  output int          fail_count
);

  import urupf_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] verdict;
    logic [7:0] hbyte;
    logic       allowed;
    logic       run_end;
  } reply_t;

  logic [7:0]  hdr [HDR_LEN];
  int unsigned hdr_fill;
  bit          rule_bits [RULE_ENTRIES];
  logic [15:0] ctrl_port;
  reply_t      replies [$];

  function automatic reply_t make_reply(input logic [1:0] kind, input logic [1:0] verdict,
                                        input logic [7:0] hbyte, input logic allowed,
                                        input logic run_end);
    reply_t r;
    r.kind = kind;
    r.verdict = verdict;
    r.hbyte = hbyte;
    r.allowed = allowed;
    r.run_end = run_end;
    return r;
  endfunction

  // Judges the buffered packet; an accepted update also writes the rule and
  // turns the buffer into the reply header.
  function automatic logic [1:0] decide_packet();
    logic [15:0] key;
    logic [7:0] tmp;
    if (hdr_fill < LEN_ETH || {hdr[POS_ETYPE_HI], hdr[POS_ETYPE_LO]} != ETYPE_IPV4) begin
      return VERDICT_PASS;
    end
    if (hdr_fill < LEN_IP || hdr[POS_PROTO] != PROTO_UDP) begin
      return VERDICT_PASS;
    end
    if (hdr_fill < LEN_UDP || {hdr[POS_DPORT_HI], hdr[POS_DPORT_LO]} != ctrl_port) begin
      return VERDICT_PASS;
    end
    if (hdr_fill < HDR_LEN || hdr[POS_CMD] > CMD_MAX) begin
      return VERDICT_PASS;
    end
    key = {hdr[POS_KEY_HI], hdr[POS_KEY_LO]};
    if (key >= RULE_ENTRIES) begin
      return VERDICT_ABORT;
    end
    rule_bits[key] = hdr[POS_CMD][0];
    hdr[POS_RESP] = RESP_CODE;
    for (int i = 0; i < 6; i++) begin
      tmp = hdr[i];
      hdr[i] = hdr[i + 6];
      hdr[i + 6] = tmp;
    end
    for (int i = 26; i < 30; i++) begin
      tmp = hdr[i];
      hdr[i] = hdr[i + 4];
      hdr[i + 4] = tmp;
    end
    for (int i = 34; i < 36; i++) begin
      tmp = hdr[i];
      hdr[i] = hdr[i + 2];
      hdr[i + 2] = tmp;
    end
    return VERDICT_TX;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    logic [1:0] v;
    logic [15:0] idx;
    if (rst) begin
      replies.delete();
      hdr_fill = 0;
      ctrl_port = CONTROL_PORT_RESET;
      fail_count = 0;
      foreach (rule_bits[i]) rule_bits[i] = 1'b0;
    end else begin
      if (cfg_wen) begin
        ctrl_port = cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies.size() == 0) begin
          $error("result word with none owed: tuser %0h, tdata %0h, tlast %0b",
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          want = replies.pop_front();
          check_field("out_kind", 8'(want.kind), 8'(m_axis_tuser));
          check_field("verdict", 8'(want.verdict), 8'(m_axis_tdata[1:0]));
          check_field("header_byte", want.hbyte, m_axis_tdata[9:2]);
          check_field("rule_allowed", 8'(want.allowed), 8'(m_axis_tdata[10]));
          check_field("tdata padding", 8'h00, 8'(m_axis_tdata[15:11]));
          check_field("run_end", 8'(want.run_end), 8'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          idx = s_axis_tdata[23:8];
          replies.push_back(make_reply(KIND_QUERY, VERDICT_PASS, 8'h00,
                                       idx < RULE_ENTRIES ? rule_bits[idx] : 1'b0, 1'b1));
        end else begin
          if (hdr_fill < HDR_LEN) begin
            hdr[hdr_fill] = s_axis_tdata[7:0];
            hdr_fill++;
          end
          if (s_axis_tlast) begin
            v = decide_packet();
            hdr_fill = 0;
            if (v != VERDICT_TX) begin
              replies.push_back(make_reply(KIND_VERDICT, v, 8'h00, 1'b0, 1'b1));
            end else begin
              replies.push_back(make_reply(KIND_VERDICT, v, 8'h00, 1'b0, 1'b0));
              for (int i = 0; i < HDR_LEN; i++) begin
                replies.push_back(make_reply(KIND_HEADER, VERDICT_PASS, hdr[i], 1'b0,
                                             i == HDR_LEN - 1));
              end
            end
          end
        end
      end
    end
    outstanding <= replies.size();
  end

endmodule

// ===== test/tb_udp_rule_update_packet_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_udp_rule_update_packet_filter
// Drives packet bytes and rule queries into the filter with random gaps and
// random receiver stalls. A directed part covers short, non-IPv4, non-UDP,
// foreign-port and bad-command packets and a long update at the top key
// with queries inside the packet; random phases then run well-formed
// updates with random content, broken and noise packets and queries under
// several control port settings. The checker module does all comparison.
// ----------------------------------------------------------------------------
module tb_udp_rule_update_packet_filter;

  import urupf_pkg::*;

  typedef enum int {FLAW_SHORT, FLAW_ETYPE, FLAW_PROTO, FLAW_PORT, FLAW_CMD} flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;

  int          outstanding;
  int          fail_count;
  logic        steady = 1'b0;
  int          sent = 0;
  logic [15:0] ctrl = CONTROL_PORT_RESET;
  logic [15:0] key_pool [8];
  logic [7:0]  frame [$];

  udp_rule_update_packet_filter dut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  urupf_reply_check reply_check (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .outstanding(outstanding),
    .fail_count(fail_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 23);
    end
  end

  task automatic send_word(input logic req, input logic [7:0] b, input logic lst,
                           input logic [15:0] port);
    while (!steady && $urandom_range(0, 99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {port, b};
    s_axis_tlast <= lst;
    s_axis_tuser <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_query(input logic [15:0] port);
    send_word(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), port);
  endtask

  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 99) < 75) begin
      return key_pool[$urandom_range(0, 7)];
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic make_update(input logic [7:0] cmd, input logic [15:0] key,
                             input logic [15:0] dport, input int len);
    frame.delete();
    for (int i = 0; i < HDR_LEN || i < len; i++) frame.push_back(8'($urandom_range(0, 255)));
    frame[POS_ETYPE_HI] = ETYPE_IPV4[15:8];
    frame[POS_ETYPE_LO] = ETYPE_IPV4[7:0];
    frame[POS_PROTO] = PROTO_UDP;
    frame[POS_DPORT_HI] = dport[15:8];
    frame[POS_DPORT_LO] = dport[7:0];
    frame[POS_CMD] = cmd;
    frame[POS_KEY_HI] = key[15:8];
    frame[POS_KEY_LO] = key[7:0];
    while (frame.size() > len) void'(frame.pop_back());
  endtask

  task automatic spoil_frame(input flaw_t flaw);
    int keep;
    case (flaw)
      FLAW_SHORT: begin
        keep = $urandom_range(1, HDR_LEN - 1);
        while (frame.size() > keep) void'(frame.pop_back());
      end
      FLAW_ETYPE: frame[POS_ETYPE_LO] ^= 8'($urandom_range(1, 255));
      FLAW_PROTO: frame[POS_PROTO] ^= 8'($urandom_range(1, 255));
      FLAW_PORT: frame[POS_DPORT_LO] ^= 8'($urandom_range(1, 255));
      default: frame[POS_CMD] = 8'($urandom_range(CMD_MAX + 1, 255));
    endcase
  endtask

  task automatic send_frame(input int query_pct);
    for (int i = 0; i < frame.size(); i++) begin
      if ($urandom_range(0, 99) < query_pct) begin
        send_query(pick_key());
      end
      send_word(1'b0, frame[i], i == frame.size() - 1, 16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic drain(input int extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_port(input logic [15:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    ctrl = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    int pick;
    int len;
    int phase_start;
    logic [15:0] phase_ports [3];

    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = 16'($urandom_range(0, 65535));
    phase_ports[0] = 16'($urandom_range(0, 65535));
    phase_ports[1] = 16'h0000;
    phase_ports[2] = 16'hFFFF;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // The first packets run with the control port as it comes out of reset.
    send_query(16'h0000);
    send_query(16'hFFFF);
    frame.delete();
    frame.push_back(8'hFF);
    send_frame(0);
    make_update(8'd1, 16'hFFFF, ctrl, HDR_LEN + 4);
    send_frame(10);
    send_query(16'hFFFF);
    make_update(8'd1, 16'h0000, ctrl, int'(LEN_ETH));
    spoil_frame(FLAW_ETYPE);
    send_frame(0);
    make_update(8'd1, 16'h0000, ctrl, int'(LEN_IP));
    spoil_frame(FLAW_PROTO);
    send_frame(0);
    make_update(8'd1, 16'h0000, ctrl, int'(LEN_UDP));
    spoil_frame(FLAW_PORT);
    send_frame(0);
    make_update(CMD_MAX + 8'd1, 16'h0000, ctrl, HDR_LEN);
    send_frame(0);
    send_query(16'hFFFF);
    send_query(16'h0000);

    for (int phase = 0; phase < 3; phase++) begin
      drain(4);
      set_port(phase_ports[phase]);
      steady <= (phase == 2);
      phase_start = sent;
      while (sent - phase_start < 12) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          send_query($urandom_range(0, 99) < 70 ? pick_key() : 16'($urandom_range(0, 65535)));
        end else begin
          len = $urandom_range(0, 99) < 80 ? HDR_LEN : $urandom_range(HDR_LEN + 1, 60);
          make_update(8'($urandom_range(0, 1)), pick_key(), ctrl, len);
          if (pick >= 90) begin
            frame.delete();
            len = $urandom_range(1, 64);
            for (int i = 0; i < len; i++) frame.push_back(8'($urandom_range(0, 255)));
          end else if (pick >= 75) begin
            spoil_frame(flaw_t'($urandom_range(0, 4)));
          end
          send_frame(5);
        end
      end
    end

    drain(60);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/urupf_pkg.sv
sv/urupf_hdr_mem.sv
sv/urupf_rule_mem.sv
sv/urupf_parser.sv
sv/udp_rule_update_packet_filter.sv
test/urupf_reply_check.sv
test/tb_udp_rule_update_packet_filter.sv
